// File: design/avang_pkg.sv
// ----------------------------------------------------------------------------
// Anticlockwise vector angle package
// Shared widths, constants, the sideband record and the arctangent table.
// ----------------------------------------------------------------------------
package avang_pkg;

   localparam int DOT_W = 36;
   localparam int RAD_W = 64;
   localparam int CX_W  = 38;
   localparam int CZ_W  = 36;
   localparam int SQRT_CELLS = 32;
   localparam int ATAN_LEN = 32;
   localparam int ANGLE_W = 16;

   localparam logic signed [CZ_W-1:0] HALF_TURN    = CZ_W'(64'sd2147483648);
   localparam logic signed [CZ_W-1:0] QUARTER_TURN = CZ_W'(64'sd1073741824);
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd51471;

   typedef struct packed {
      logic                    valid;
      logic                    degen;
      logic                    tri_neg;
      logic signed [DOT_W-1:0] dot;
   } side_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// File: design/anticlockwise_vector_angle.sv
// ----------------------------------------------------------------------------
// Anticlockwise vector angle
// Angle from a to b, anticlockwise about view, via an integer square root
// chain and a CORDIC vectoring chain.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy is never raised.
// Each result is shown for one cycle on rsp_strobe and cannot be stalled.
// Reset clears the valid flags of every stage and the whole sideband record; other payload is not reset.
// ----------------------------------------------------------------------------
module anticlockwise_vector_angle #(
   parameter int COORD_BITS   = 16,
   parameter int ANGLE_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_a_x,
   input  logic signed [COORD_BITS-1:0]  req_a_y,
   input  logic signed [COORD_BITS-1:0]  req_a_z,
   input  logic signed [COORD_BITS-1:0]  req_b_x,
   input  logic signed [COORD_BITS-1:0]  req_b_y,
   input  logic signed [COORD_BITS-1:0]  req_b_z,
   input  logic signed [COORD_BITS-1:0]  req_view_x,
   input  logic signed [COORD_BITS-1:0]  req_view_y,
   input  logic signed [COORD_BITS-1:0]  req_view_z,
   output logic                          rsp_strobe,
   output logic [avang_pkg::ANGLE_W-1:0] rsp_angle,
   output logic                          rsp_degenerate
);
   import avang_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EW = COORD_BITS + 16;
   localparam int NS = (ANGLE_STAGES < ATAN_LEN) ? ANGLE_STAGES : ATAN_LEN;

   assign busy = 1'b0;

   // Stage 1: capture.
   logic signed [CB-1:0] c1_ff [9];
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      c1_ff[0] <= req_a_x;    c1_ff[1] <= req_a_y;    c1_ff[2] <= req_a_z;
      c1_ff[3] <= req_b_x;    c1_ff[4] <= req_b_y;    c1_ff[5] <= req_b_z;
      c1_ff[6] <= req_view_x; c1_ff[7] <= req_view_y; c1_ff[8] <= req_view_z;
   end

   // Stage 2: magnitudes and scale shift per vector.
   logic [CB-1:0] mag_in [9];
   logic [CB-1:0] mx_in  [3];
   logic [4:0]    msb_in [3];
   logic          left_in [3];
   logic [4:0]    k_in   [3];
   logic          at_limit;
   logic          degen_in;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         mag_in[i] = c1_ff[i][CB-1] ? CB'(-c1_ff[i]) : CB'(c1_ff[i]);
      end
      for (int g = 0; g < 3; g++) begin
         mx_in[g] = mag_in[3*g];
         if (mag_in[3*g+1] > mx_in[g]) mx_in[g] = mag_in[3*g+1];
         if (mag_in[3*g+2] > mx_in[g]) mx_in[g] = mag_in[3*g+2];
         msb_in[g] = 5'd0;
         for (int j = 0; j < CB; j++) begin
            if (mx_in[g][j]) msb_in[g] = 5'(j);
         end
         at_limit = ((mx_in[g] >> (msb_in[g] - 5'd15)) == CB'(33'd32768));
         if (msb_in[g] >= 5'd15) begin
            left_in[g] = 1'b0;
            k_in[g]    = msb_in[g] - 5'd15 + {4'd0, ~at_limit};
         end else begin
            left_in[g] = 1'b1;
            k_in[g]    = (msb_in[g] < 5'd14) ? 5'd14 - msb_in[g] : 5'd0;
         end
      end
      degen_in = (c1_ff[0] == '0 && c1_ff[1] == '0 && c1_ff[2] == '0) ||
                 (c1_ff[3] == '0 && c1_ff[4] == '0 && c1_ff[5] == '0);
   end

   logic [CB-1:0] mag2_ff [9];
   logic          neg2_ff [9];
   logic          left2_ff [3];
   logic [4:0]    k2_ff [3];
   logic          v2_ff, d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      d2_ff <= degen_in;
      for (int i = 0; i < 9; i++) begin
         mag2_ff[i] <= mag_in[i];
         neg2_ff[i] <= c1_ff[i][CB-1];
      end
      for (int g = 0; g < 3; g++) begin
         left2_ff[g] <= left_in[g];
         k2_ff[g]    <= k_in[g];
      end
   end

   // Stage 3: apply the scale.
   logic [EW-1:0]     wide_in [9];
   logic signed [16:0] s3_in [9];
   logic signed [16:0] s3_ff [9];
   logic               v3_ff, d3_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         wide_in[i] = left2_ff[i/3] ? ({16'd0, mag2_ff[i]} << k2_ff[i/3])
                                    : ({16'd0, mag2_ff[i]} >> k2_ff[i/3]);
         s3_in[i] = neg2_ff[i] ? -$signed({1'b0, wide_in[i][15:0]})
                               : $signed({1'b0, wide_in[i][15:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      d3_ff <= d2_ff;
      s3_ff <= s3_in;
   end

   // Stage 4: products.
   logic signed [33:0] p4_ff [15];
   logic signed [16:0] vw4_ff [3];
   logic               v4_ff, d4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      d4_ff <= d3_ff;
      for (int k = 0; k < 3; k++) begin
         p4_ff[k]   <= s3_ff[k] * s3_ff[3+k];
         p4_ff[3+k] <= s3_ff[k] * s3_ff[k];
         p4_ff[6+k] <= s3_ff[3+k] * s3_ff[3+k];
         vw4_ff[k]  <= s3_ff[6+k];
      end
      p4_ff[9]  <= s3_ff[1] * s3_ff[5];
      p4_ff[10] <= s3_ff[2] * s3_ff[4];
      p4_ff[11] <= s3_ff[2] * s3_ff[3];
      p4_ff[12] <= s3_ff[0] * s3_ff[5];
      p4_ff[13] <= s3_ff[0] * s3_ff[4];
      p4_ff[14] <= s3_ff[1] * s3_ff[3];
   end

   // Stage 5: sums.
   logic signed [DOT_W-1:0] dot5_ff;
   logic [33:0]             na5_in, nb5_in;
   logic [31:0]             na5_ff, nb5_ff;
   logic signed [34:0]      cr5_ff [3];
   logic signed [16:0]      vw5_ff [3];
   logic                    v5_ff, d5_ff;

   assign na5_in = 34'(p4_ff[3]) + 34'(p4_ff[4]) + 34'(p4_ff[5]);
   assign nb5_in = 34'(p4_ff[6]) + 34'(p4_ff[7]) + 34'(p4_ff[8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      d5_ff   <= d4_ff;
      dot5_ff <= DOT_W'(p4_ff[0]) + DOT_W'(p4_ff[1]) + DOT_W'(p4_ff[2]);
      na5_ff  <= na5_in[31:0];
      nb5_ff  <= nb5_in[31:0];
      cr5_ff[0] <= 35'(p4_ff[9])  - 35'(p4_ff[10]);
      cr5_ff[1] <= 35'(p4_ff[11]) - 35'(p4_ff[12]);
      cr5_ff[2] <= 35'(p4_ff[13]) - 35'(p4_ff[14]);
      vw5_ff  <= vw4_ff;
   end

   // Stage 6: wide products.
   logic [DOT_W-1:0]        adot_full;
   logic [31:0]             adot6_in;
   logic [RAD_W-1:0]        nn6_ff, dd6_ff;
   logic signed [51:0]      t6_ff [3];
   logic signed [DOT_W-1:0] dot6_ff;
   logic                    v6_ff, d6_ff;

   assign adot_full = dot5_ff[DOT_W-1] ? DOT_W'(-dot5_ff) : DOT_W'(dot5_ff);
   assign adot6_in  = adot_full[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      d6_ff   <= d5_ff;
      dot6_ff <= dot5_ff;
      nn6_ff  <= RAD_W'(na5_ff) * RAD_W'(nb5_ff);
      dd6_ff  <= RAD_W'(adot6_in) * RAD_W'(adot6_in);
      for (int k = 0; k < 3; k++) begin
         t6_ff[k] <= 52'(vw5_ff[k]) * 52'(cr5_ff[k]);
      end
   end

   // Stage 7: radicand and triple product sign.
   logic signed [53:0] tri7_in;
   side_type           side7_ff;
   logic [RAD_W-1:0]   rad7_ff;

   assign tri7_in = 54'(t6_ff[0]) + 54'(t6_ff[1]) + 54'(t6_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         side7_ff <= '0;
      end else begin
         side7_ff.valid   <= v6_ff;
         side7_ff.degen   <= d6_ff;
         side7_ff.tri_neg <= tri7_in[53];
         side7_ff.dot     <= dot6_ff;
      end
      rad7_ff <= nn6_ff - dd6_ff;
   end

   // Square root chain.
   side_type         sq_side [SQRT_CELLS+1];
   logic [RAD_W-1:0] sq_rem  [SQRT_CELLS+1];
   logic [RAD_W-1:0] sq_root [SQRT_CELLS+1];

   assign sq_side[0] = side7_ff;
   assign sq_rem[0]  = rad7_ff;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      avang_isqrt_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (sq_side[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .side_o (sq_side[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1])
      );
   end

   // Quadrant fold ahead of the rotations.
   side_type               cd_side [NS+1];
   logic                   cd_zero [NS+1];
   logic signed [CX_W-1:0] cd_x [NS+1];
   logic signed [CX_W-1:0] cd_y [NS+1];
   logic signed [CZ_W-1:0] cd_z [NS+1];

   side_type               pre_side_ff;
   logic                   pre_zero_ff;
   logic signed [CX_W-1:0] pre_x_ff, pre_y_ff, pre_x_in, pre_y_in, ys, dx_ext;
   logic signed [CZ_W-1:0] pre_z_ff, pre_z_in;

   always_comb begin
      ys     = $signed({1'b0, sq_root[SQRT_CELLS][CX_W-2:0]});
      dx_ext = CX_W'(sq_side[SQRT_CELLS].dot);
      if (dx_ext < 0) begin
         pre_x_in = ys;
         pre_y_in = -dx_ext;
         pre_z_in = QUARTER_TURN;
      end else begin
         pre_x_in = dx_ext;
         pre_y_in = ys;
         pre_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_side_ff <= '0;
      end else begin
         pre_side_ff <= sq_side[SQRT_CELLS];
      end
      pre_zero_ff <= (sq_root[SQRT_CELLS] == '0);
      pre_x_ff    <= pre_x_in;
      pre_y_ff    <= pre_y_in;
      pre_z_ff    <= pre_z_in;
   end

   assign cd_side[0] = pre_side_ff;
   assign cd_zero[0] = pre_zero_ff;
   assign cd_x[0]    = pre_x_ff;
   assign cd_y[0]    = pre_y_ff;
   assign cd_z[0]    = pre_z_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      avang_cordic_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (cd_side[i]),
         .zero_i (cd_zero[i]),
         .x_i    (cd_x[i]),
         .y_i    (cd_y[i]),
         .z_i    (cd_z[i]),
         .side_o (cd_side[i+1]),
         .zero_o (cd_zero[i+1]),
         .x_o    (cd_x[i+1]),
         .y_o    (cd_y[i+1]),
         .z_o    (cd_z[i+1])
      );
   end

   // Clamp and mirror.
   side_type               fin_side;
   logic signed [CZ_W-1:0] zc;
   logic [32:0]            turn_in, turn_ff;
   logic                   vf_ff, df_ff;

   assign fin_side = cd_side[NS];

   always_comb begin
      if (cd_zero[NS]) begin
         zc = (fin_side.dot > 0) ? '0 : HALF_TURN;
      end else if (cd_z[NS] < 0) begin
         zc = '0;
      end else if (cd_z[NS] > HALF_TURN) begin
         zc = HALF_TURN;
      end else begin
         zc = cd_z[NS];
      end
      turn_in = zc[32:0];
      if (fin_side.tri_neg && turn_in != '0) begin
         turn_in = 33'h1_0000_0000 - turn_in;
      end
      if (fin_side.degen) begin
         turn_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= fin_side.valid;
      end
      df_ff   <= fin_side.degen;
      turn_ff <= turn_in;
   end

   // Conversion to radians.
   logic [64:0] prod_ff, rnd_in;
   logic        vp_ff, dp_ff;
   logic [16:0] ang_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= vf_ff;
      end
      dp_ff   <= df_ff;
      prod_ff <= 65'(turn_ff) * 65'(TWO_PI_Q29);
   end

   assign rnd_in = prod_ff + (65'd1 << 47);
   assign ang_in = rnd_in[64:48];

   logic                 strobe_ff, degen_ff;
   logic [ANGLE_W-1:0]   angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vp_ff;
      end
      degen_ff <= dp_ff;
      angle_ff <= (ang_in > 17'(ANGLE_MAX)) ? ANGLE_MAX : ang_in[15:0];
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_angle      = angle_ff;
   assign rsp_degenerate = degen_ff;
endmodule

// File: design/avang_isqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module avang_isqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  avang_pkg::side_type           side_i,
   input  logic [avang_pkg::RAD_W-1:0]   rem_i,
   input  logic [avang_pkg::RAD_W-1:0]   root_i,
   output avang_pkg::side_type           side_o,
   output logic [avang_pkg::RAD_W-1:0]   rem_o,
   output logic [avang_pkg::RAD_W-1:0]   root_o
);
   import avang_pkg::*;

   localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (62 - 2 * STEP);

   side_type         side_ff;
   logic [RAD_W-1:0] rem_ff, root_ff, rem_in, root_in, trial;

   always_comb begin
      trial = root_i + BIT;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign side_o = side_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
endmodule

// File: design/avang_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation of the arctangent chain, registered.
// ----------------------------------------------------------------------------
module avang_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  avang_pkg::side_type                side_i,
   input  logic                               zero_i,
   input  logic signed [avang_pkg::CX_W-1:0]  x_i,
   input  logic signed [avang_pkg::CX_W-1:0]  y_i,
   input  logic signed [avang_pkg::CZ_W-1:0]  z_i,
   output avang_pkg::side_type                side_o,
   output logic                               zero_o,
   output logic signed [avang_pkg::CX_W-1:0]  x_o,
   output logic signed [avang_pkg::CX_W-1:0]  y_o,
   output logic signed [avang_pkg::CZ_W-1:0]  z_o
);
   import avang_pkg::*;

   localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_turns(5'(STEP)));

   side_type               side_ff;
   logic                   zero_ff;
   logic signed [CX_W-1:0] x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [CZ_W-1:0] z_ff, z_in;

   always_comb begin
      dx = y_i >>> STEP;
      dy = x_i >>> STEP;
      if (y_i > 0) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
      zero_ff <= zero_i;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign side_o = side_ff;
   assign zero_o = zero_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
endmodule
